FILE: design/tda_pkg.sv
package tda_pkg;

  // Fixed field widths
  localparam int unsigned VOL_W = 16;   // volume element, unsigned Q0.16
  localparam int unsigned GAP_W = 16;   // energy gap, signed Q8.8
  localparam int unsigned OUT_W = 32;   // every result field
  localparam int unsigned MU2_W = 64;   // squared magnitude, Q32.32

  localparam logic [VOL_W-1:0] VOL_RESET = 16'hFFFF;

  // osc = floor(2*t*|gap|/3) >> 8 = floor((t*|gap| >> 7) / 3)
  localparam int unsigned OSC_PRE_SHIFT = 7;
  localparam int unsigned MU2_DROP      = 16;  // t = mu2 >> 16

endpackage

FILE: design/tda_ifs.sv
interface tda_in_if import tda_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COORD_WIDTH  = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] psi_hole;
  logic signed [SAMPLE_WIDTH-1:0] psi_elec;
  logic signed [COORD_WIDTH-1:0]  coord_x;
  logic signed [COORD_WIDTH-1:0]  coord_y;
  logic signed [COORD_WIDTH-1:0]  coord_z;
  logic signed [GAP_W-1:0]        energy_gap;
  logic                           last_point;

  modport source (
    output valid, psi_hole, psi_elec, coord_x, coord_y, coord_z, energy_gap, last_point,
    input  ready
  );
  modport sink (
    input  valid, psi_hole, psi_elec, coord_x, coord_y, coord_z, energy_gap, last_point,
    output ready
  );
endinterface

interface tda_out_if import tda_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] dip_x;
  logic signed [OUT_W-1:0] dip_y;
  logic signed [OUT_W-1:0] dip_z;
  logic        [OUT_W-1:0] dip_magnitude;
  logic signed [OUT_W-1:0] osc_strength;

  modport source (
    output valid, dip_x, dip_y, dip_z, dip_magnitude, osc_strength,
    input  ready
  );
  modport sink (
    input  valid, dip_x, dip_y, dip_z, dip_magnitude, osc_strength,
    output ready
  );
endinterface

FILE: design/transition_dipole_accumulator.sv
// Transition dipole accumulator.
// point_i (valid/ready): one grid point per beat - both wavefunction samples
//   (Q1.15), x/y/z coordinates (Q8.8), energy gap (Q8.8, used on the last
//   point only) and last_point. One point is taken per cycle unless stalled.
// result_o (valid/ready): one beat per state pair, after its last point:
//   dipole vector, magnitude and oscillator strength, all 32-bit Q16.16.
// cfg_we_i/cfg_wdata_i: volume element (unsigned Q0.16); write while idle.
// A last point passes the sample-product and coordinate-term stages and
//   is written into the finishing queue, which the finishing unit pops
//   while idle; the unit then scales the three components, squares and
//   sums them, multiplies by the gap, runs the one-bit-per-cycle square
//   root and loads the output register.
// Throughput: one point per cycle unless point_i stalls. The finishing unit
//   takes the next entry only after loading its last result. A two
//   entry queue holds finished sums, so a new pair streams while the last
//   one finishes; only a last point meeting a full queue stalls point_i.
// Reset: accumulators clear, queue and output empty, volume element 0xFFFF.
// A stalled receiver holds the result register and the finishing unit;
//   sums still enter the queue until it fills; then a last point stalls point_i.
module transition_dipole_accumulator import tda_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned SUM_WIDTH    = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tda_in_if.sink           point_i,
  tda_out_if.source        result_o,
  input  logic             cfg_we_i,
  input  logic [VOL_W-1:0] cfg_wdata_i
);

  // sums carry SAMPLE_WIDTH-1 + COORD_WIDTH/2 fraction bits
  localparam int unsigned DIP_SHIFT = SAMPLE_WIDTH - 1 + COORD_WIDTH / 2;
  localparam int unsigned ENTRY_W   = 3 * SUM_WIDTH + GAP_W;

  logic [VOL_W-1:0]   vol_q;
  logic               push, full, pop, entry_valid;
  logic [ENTRY_W-1:0] entry_in, entry_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= VOL_RESET;
    end else if (cfg_we_i) begin
      vol_q <= cfg_wdata_i;
    end
  end

  // front: product pipeline and saturating accumulators
  tda_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COORD_WIDTH  (COORD_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_i),
    .push_o  (push),
    .entry_o (entry_in),
    .full_i  (full)
  );

  // finished sums plus gap, waiting for the back end
  tda_fifo #(
    .DATA_W (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (entry_valid),
    .data_o  (entry_out)
  );

  // back: scaling, magnitude, oscillator strength, result register
  tda_back #(
    .SUM_WIDTH (SUM_WIDTH),
    .DIP_SHIFT (DIP_SHIFT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vol_i         (vol_q),
    .entry_valid_i (entry_valid),
    .entry_i       (entry_out),
    .pop_o         (pop),
    .result_o      (result_o)
  );

endmodule

FILE: design/tda_front.sv
module tda_front import tda_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned SUM_WIDTH    = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tda_in_if.sink                           point_i,
  output logic                             push_o,
  output logic [3*SUM_WIDTH+GAP_W-1:0]     entry_o,
  input  logic                             full_i
);

  localparam int unsigned P_W    = SAMPLE_WIDTH + 1;
  localparam int unsigned TERM_W = P_W + COORD_WIDTH;
  localparam int unsigned ACC_W  = ((SUM_WIDTH > TERM_W) ? SUM_WIDTH : TERM_W) + 1;
  localparam logic signed [ACC_W-1:0] SUM_HI =
    ACC_W'(signed'({1'b0, {(SUM_WIDTH-1){1'b1}}}));
  localparam logic signed [ACC_W-1:0] SUM_LO =
    ACC_W'(signed'({1'b1, {(SUM_WIDTH-1){1'b0}}}));

  // stage 1: sample product
  logic                           s1_v_q, s1_last_q;
  logic signed [P_W-1:0]          s1_p_q;
  logic signed [COORD_WIDTH-1:0]  s1_cx_q, s1_cy_q, s1_cz_q;
  logic signed [GAP_W-1:0]        s1_gap_q;
  // stage 2: coordinate terms
  logic                           s2_v_q, s2_last_q;
  logic signed [TERM_W-1:0]       s2_tx_q, s2_ty_q, s2_tz_q;
  logic signed [GAP_W-1:0]        s2_gap_q;
  // accumulators
  logic signed [SUM_WIDTH-1:0]    sum_x_q, sum_y_q, sum_z_q;
  logic signed [SUM_WIDTH-1:0]    sum_x_d, sum_y_d, sum_z_d;

  logic                           advance;
  logic signed [2*SAMPLE_WIDTH-1:0] he;
  logic signed [2*SAMPLE_WIDTH-1:0] he_sh;
  logic signed [TERM_W-1:0]       tx, ty, tz;

  function automatic logic signed [SUM_WIDTH-1:0] sat_acc(
    input logic signed [SUM_WIDTH-1:0] s,
    input logic signed [TERM_W-1:0]    t
  );
    logic signed [ACC_W-1:0] r;
    r = ACC_W'(s) + ACC_W'(t);
    if (r > SUM_HI) begin
      return SUM_HI[SUM_WIDTH-1:0];
    end else if (r < SUM_LO) begin
      return SUM_LO[SUM_WIDTH-1:0];
    end
    return r[SUM_WIDTH-1:0];
  endfunction

  // only a last point with the queue full holds the pipe
  assign advance = !(s2_v_q && s2_last_q && full_i);
  assign point_i.ready = advance;
  assign push_o = s2_v_q && s2_last_q && !full_i;

  assign he    = point_i.psi_hole * point_i.psi_elec;
  assign he_sh = he >>> (SAMPLE_WIDTH - 1);
  assign tx    = s1_p_q * s1_cx_q;
  assign ty    = s1_p_q * s1_cy_q;
  assign tz    = s1_p_q * s1_cz_q;

  assign sum_x_d = sat_acc(sum_x_q, s2_tx_q);
  assign sum_y_d = sat_acc(sum_y_q, s2_ty_q);
  assign sum_z_d = sat_acc(sum_z_q, s2_tz_q);
  assign entry_o = {s2_gap_q, sum_x_d, sum_y_d, sum_z_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
    end else if (advance) begin
      s1_v_q <= point_i.valid;
      s2_v_q <= s1_v_q;
      if (s2_v_q) begin
        if (s2_last_q) begin
          sum_x_q <= '0;
          sum_y_q <= '0;
          sum_z_q <= '0;
        end else begin
          sum_x_q <= sum_x_d;
          sum_y_q <= sum_y_d;
          sum_z_q <= sum_z_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_p_q    <= he_sh[P_W-1:0];
      s1_cx_q   <= point_i.coord_x;
      s1_cy_q   <= point_i.coord_y;
      s1_cz_q   <= point_i.coord_z;
      s1_gap_q  <= point_i.energy_gap;
      s1_last_q <= point_i.last_point;
      s2_tx_q   <= tx;
      s2_ty_q   <= ty;
      s2_tz_q   <= tz;
      s2_gap_q  <= s1_gap_q;
      s2_last_q <= s1_last_q;
    end
  end

endmodule

FILE: design/tda_fifo.sv
module tda_fifo #(
  parameter int unsigned DATA_W = 160
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  // two entries of finished sums, both waiting for the back end
  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/tda_back.sv
module tda_back import tda_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 48,
  parameter int unsigned DIP_SHIFT = 23
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [VOL_W-1:0]             vol_i,
  input  logic                         entry_valid_i,
  input  logic [3*SUM_WIDTH+GAP_W-1:0] entry_i,
  output logic                         pop_o,
  tda_out_if.source                    result_o
);

  localparam int unsigned PROD_W = SUM_WIDTH + VOL_W;
  localparam int unsigned T_W    = MU2_W - MU2_DROP;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_CONV  = 3'd2;
  localparam logic [2:0] ST_SQ    = 3'd3;
  localparam logic [2:0] ST_SQACC = 3'd4;
  localparam logic [2:0] ST_OSC   = 3'd5;
  localparam logic [2:0] ST_ITER  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [1:0] LAST_IDX = 2'd2;
  localparam logic [4:0] LAST_CNT = 5'd31;

  logic [2:0]             state_q, state_d;
  logic [1:0]             idx_q;
  logic [4:0]             cnt_q;
  logic                   out_v_q;
  logic                   out_load;

  logic [SUM_WIDTH-1:0]   mag_q [3];
  logic                   neg_q [3];
  logic                   gap_neg_q;
  logic [GAP_W-1:0]       gap_mag_q;
  logic [PROD_W-1:0]      prod_q;
  logic signed [OUT_W-1:0] dip_q [3];
  logic [MU2_W-1:0]       sq_q, mu2_q;
  logic [MU2_W-1:0]       div_q, div_d;
  logic [1:0]             rem_q, rem_d;
  logic [MU2_W-1:0]       rt_op_q, rt_res_q, rt_one_q;
  logic [MU2_W-1:0]       rt_op_d, rt_res_d, rt_try;

  logic [SUM_WIDTH-1:0]   sums [3];
  logic signed [GAP_W-1:0] gap_in;
  logic signed [OUT_W-1:0] dip_d;
  logic signed [2*OUT_W-1:0] sq_d;
  logic [MU2_W-1:0]       osc_d;
  logic [T_W-1:0]         t_val;

  function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic [MU2_W-1:0] q);
    if (neg) begin
      if (q > MU2_W'(64'h8000_0000)) begin
        return 32'h8000_0000;
      end
      return (~q[OUT_W-1:0]) + 32'd1;
    end
    if (q > MU2_W'(64'h7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] scale(input logic neg, input logic [PROD_W-1:0] p);
    logic [MU2_W-1:0] q;
    logic             frac;
    q    = MU2_W'(p >> DIP_SHIFT);
    frac = (p << (PROD_W - DIP_SHIFT)) != '0;
    if ((p >> MU2_W) != '0) begin
      return sat32(neg, '1);
    end
    return sat32(neg, q + MU2_W'(neg && frac));
  endfunction

  assign sums[0] = entry_i[3*SUM_WIDTH-1:2*SUM_WIDTH];
  assign sums[1] = entry_i[2*SUM_WIDTH-1:SUM_WIDTH];
  assign sums[2] = entry_i[SUM_WIDTH-1:0];
  assign gap_in  = entry_i[3*SUM_WIDTH+GAP_W-1:3*SUM_WIDTH];

  assign pop_o    = (state_q == ST_IDLE) && entry_valid_i;
  assign out_load = (state_q == ST_OUT) && (!out_v_q || result_o.ready);
  assign result_o.valid = out_v_q;

  assign dip_d = signed'(scale(neg_q[idx_q], prod_q));
  assign sq_d  = dip_q[idx_q] * dip_q[idx_q];
  assign t_val = mu2_q[MU2_W-1:MU2_DROP];
  assign osc_d = ({{GAP_W{1'b0}}, t_val} * {{T_W{1'b0}}, gap_mag_q}) >> OSC_PRE_SHIFT;

  // square root: one result bit per cycle
  assign rt_try = rt_res_q + rt_one_q;
  always_comb begin
    if (rt_op_q >= rt_try) begin
      rt_op_d  = rt_op_q - rt_try;
      rt_res_d = (rt_res_q >> 1) + rt_one_q;
    end else begin
      rt_op_d  = rt_op_q;
      rt_res_d = rt_res_q >> 1;
    end
  end

  // divide by three: eight quotient bits per cycle, MSB first
  always_comb begin
    logic [2:0] r;
    logic       qb;
    div_d = div_q;
    rem_d = rem_q;
    for (int i = 0; i < 8; i++) begin
      r  = {rem_d, div_d[MU2_W-1]};
      qb = (r >= 3'd3);
      if (qb) begin
        r = r - 3'd3;
      end
      rem_d = r[1:0];
      div_d = {div_d[MU2_W-2:0], qb};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (entry_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_CONV;
      ST_CONV:  state_d = (idx_q == LAST_IDX) ? ST_SQ : ST_MUL;
      ST_SQ:    state_d = ST_SQACC;
      ST_SQACC: state_d = (idx_q == LAST_IDX) ? ST_OSC : ST_SQ;
      ST_OSC:   state_d = ST_ITER;
      ST_ITER:  if (cnt_q == LAST_CNT) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 2'd0;
      cnt_q   <= 5'd0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE:  idx_q <= 2'd0;
        ST_CONV,
        ST_SQACC: idx_q <= (idx_q == LAST_IDX) ? 2'd0 : idx_q + 2'd1;
        ST_OSC:   cnt_q <= 5'd0;
        ST_ITER:  cnt_q <= cnt_q + 5'd1;
        default:  ;
      endcase
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= sums[i][SUM_WIDTH-1];
          mag_q[i] <= sums[i][SUM_WIDTH-1] ? (~sums[i] + 1'b1) : sums[i];
        end
        gap_neg_q <= gap_in[GAP_W-1];
        gap_mag_q <= gap_in[GAP_W-1] ? (~gap_in + 1'b1) : gap_in;
        mu2_q     <= '0;
      end
      ST_MUL:   prod_q <= {{VOL_W{1'b0}}, mag_q[idx_q]} * {{SUM_WIDTH{1'b0}}, vol_i};
      ST_CONV:  dip_q[idx_q] <= dip_d;
      ST_SQ:    sq_q <= sq_d;
      ST_SQACC: mu2_q <= mu2_q + sq_q;
      ST_OSC: begin
        div_q    <= osc_d;
        rem_q    <= 2'd0;
        rt_op_q  <= mu2_q;
        rt_res_q <= '0;
        rt_one_q <= MU2_W'(1) << (MU2_W - 2);
      end
      ST_ITER: begin
        rt_op_q  <= rt_op_d;
        rt_res_q <= rt_res_d;
        rt_one_q <= rt_one_q >> 2;
        if (cnt_q[4:3] == 2'd0) begin
          div_q <= div_d;
          rem_q <= rem_d;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      result_o.dip_x         <= dip_q[0];
      result_o.dip_y         <= dip_q[1];
      result_o.dip_z         <= dip_q[2];
      result_o.dip_magnitude <= rt_res_q[OUT_W-1:0];
      result_o.osc_strength  <= signed'(sat32(gap_neg_q, div_q));
    end
  end

endmodule
